// ===== hdl/sha256_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and the controller/datapath command set.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned Rounds = 64;

    typedef logic [WordW-1:0] word_t;

    localparam word_t RoundK [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PadByte = 8'h80;

    // byte source for the block buffer write
    typedef enum logic [1:0] {
        SRC_DATA = 2'd0,
        SRC_PAD  = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_LEN  = 2'd3
    } byte_src_t;

    typedef struct packed {
        logic      init;        // restore initial hash, clear length
        logic      wr;          // write one byte at fill position
        byte_src_t src;
        logic      count_bits;  // add 8 to the length
        logic      start;       // begin 64-round compression
        logic      out_shift;   // rotate hash words for output
    } dp_cmd_t;

    typedef struct packed {
        logic       busy;       // compression running
        logic       block_full; // fill position wrapped to zero after 64 bytes
        logic [5:0] fill;
    } dp_stat_t;

endpackage

// ===== hdl/sha256_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, length counter, schedule and one-round-per-cycle compression.
// ----------------------------------------------------------------------------
module sha256_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sha256_pkg::dp_cmd_t   cmd,
    input  logic [7:0]            data_byte,
    output sha256_pkg::dp_stat_t  stat,
    output sha256_pkg::word_t     h0
);

    sha256_pkg::word_t h_reg [8];
    sha256_pkg::word_t v_reg [8];
    sha256_pkg::word_t w_reg [16];
    logic [5:0]  fill_reg;
    logic        full_reg;
    logic [63:0] bits_reg;
    logic        busy_reg;
    logic [5:0]  rnd_reg;
    logic        fin_reg;

    logic [7:0]  wbyte;
    logic [2:0]  lsel;
    sha256_pkg::word_t x15, x2, s0, s1, wnew, wv, b1, b0, ch, mj, t1, t2;

    always_comb begin
        lsel = fill_reg[2:0];
        case (cmd.src)
            sha256_pkg::SRC_DATA: wbyte = data_byte;
            sha256_pkg::SRC_PAD:  wbyte = sha256_pkg::PadByte;
            sha256_pkg::SRC_ZERO: wbyte = 8'h00;
            sha256_pkg::SRC_LEN:  wbyte = bits_reg[63 - 8*lsel -: 8];
            default:              wbyte = 8'h00;
        endcase
    end

    // schedule: w_reg[0] is the word for this round, shift each round
    always_comb begin
        x15  = w_reg[1];
        x2   = w_reg[14];
        s0   = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
        s1   = {x2[16:0], x2[31:17]} ^ {x2[18:0], x2[31:19]} ^ (x2 >> 10);
        wnew = w_reg[0] + s0 + w_reg[9] + s1;
        wv   = w_reg[0];
        b1 = {v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
           ^ {v_reg[4][24:0], v_reg[4][31:25]};
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + b1 + ch + sha256_pkg::RoundK[rnd_reg] + wv;
        b0 = {v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
           ^ {v_reg[0][21:0], v_reg[0][31:22]};
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = b0 + mj;
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            // bytes land big-endian straight in the schedule words
            w_reg[fill_reg[5:2]][31 - 8*fill_reg[1:0] -: 8] <= wbyte;
        end
        if (cmd.start) begin
            for (int j = 0; j < 8; j++) begin
                v_reg[j] <= h_reg[j];
            end
        end else if (busy_reg) begin
            for (int j = 0; j < 15; j++) begin
                w_reg[j] <= w_reg[j+1];
            end
            w_reg[15] <= wnew;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < 8; j++) h_reg[j] <= sha256_pkg::InitH[j];
            fill_reg <= '0;
            full_reg <= 1'b0;
            bits_reg <= '0;
            busy_reg <= 1'b0;
            rnd_reg  <= '0;
            fin_reg  <= 1'b0;
        end else begin
            fin_reg <= 1'b0;
            if (cmd.init) begin
                for (int j = 0; j < 8; j++) h_reg[j] <= sha256_pkg::InitH[j];
                bits_reg <= '0;
                fill_reg <= '0;
            end else if (cmd.out_shift) begin
                for (int j = 0; j < 7; j++) h_reg[j] <= h_reg[j+1];
                h_reg[7] <= h_reg[0];
            end else if (fin_reg) begin
                for (int j = 0; j < 8; j++) h_reg[j] <= h_reg[j] + v_reg[j];
            end
            if (cmd.wr) begin
                fill_reg <= fill_reg + 6'd1;
            end
            full_reg <= cmd.wr && (fill_reg == 6'd63);
            if (cmd.count_bits) begin
                bits_reg <= bits_reg + 64'd8;
            end
            if (cmd.start) begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end else if (busy_reg) begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    assign stat.busy       = busy_reg | fin_reg;
    assign stat.block_full = full_reg;
    assign stat.fill       = fill_reg;
    assign h0              = h_reg[0];

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> !busy_reg && !fin_reg)
        else $error("compression started while busy");
    a_no_wr_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !cmd.wr)
        else $error("buffer written during compression");
    a_fin_once: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_reg |=> !fin_reg)
        else $error("finish pulse longer than one cycle");
`endif

endmodule

// ===== hdl/sha256_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, padding, compressions and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  byte_valid,
    input  logic                  end_of_message,
    input  sha256_pkg::dp_stat_t  stat,
    output sha256_pkg::dp_cmd_t   cmd,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            out_index
);

    typedef enum logic [2:0] {
        S_IDLE, S_WAIT, S_PAD, S_ZERO, S_LEN, S_OUT
    } state_t;

    state_t     state_reg;
    logic       eom_reg;   // message end pending after the current compression
    logic       extra_reg; // pad spilled past byte 55, zero-and-length block follows
    logic       last_reg;  // running compression is the final one
    logic       kick_reg;  // start pulse issued; blocks a repeat start while busy rises
    logic [2:0] idx_reg;

    logic take;
    assign take = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd = '0;
        cmd.src = sha256_pkg::SRC_DATA;
        case (state_reg)
            S_IDLE: begin
                cmd.wr         = take && byte_valid;
                cmd.count_bits = take && byte_valid;
            end
            S_PAD: begin
                cmd.wr  = 1'b1;
                cmd.src = sha256_pkg::SRC_PAD;
            end
            S_ZERO: begin
                cmd.wr  = 1'b1;
                cmd.src = sha256_pkg::SRC_ZERO;
            end
            S_LEN: begin
                cmd.wr  = 1'b1;
                cmd.src = sha256_pkg::SRC_LEN;
            end
            S_OUT: begin
                cmd.out_shift = out_ready;
                cmd.init      = out_ready && (idx_reg == 3'd7);
            end
            default: ;
        endcase
        cmd.start = stat.block_full && !kick_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            eom_reg   <= 1'b0;
            extra_reg <= 1'b0;
            last_reg  <= 1'b0;
            kick_reg  <= 1'b0;
            idx_reg   <= '0;
        end else begin
            kick_reg <= cmd.start;
            case (state_reg)
                S_IDLE: begin
                    if (take) begin
                        eom_reg <= end_of_message;
                        if ((byte_valid && stat.fill == 6'd63) || end_of_message) begin
                            state_reg <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    // wait for the full block to leave the datapath
                    if (!stat.busy && !stat.block_full && !kick_reg) begin
                        if (last_reg) begin
                            last_reg  <= 1'b0;
                            idx_reg   <= '0;
                            state_reg <= S_OUT;
                        end else if (extra_reg) begin
                            // pad already written: fill the length block
                            extra_reg <= 1'b0;
                            state_reg <= S_ZERO;
                        end else if (eom_reg) begin
                            eom_reg   <= 1'b0;
                            state_reg <= S_PAD;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_PAD: begin
                    if (stat.fill == 6'd63) begin
                        state_reg <= S_WAIT;
                        extra_reg <= 1'b1;
                    end else if (stat.fill == 6'd55) begin
                        state_reg <= S_LEN;
                    end else begin
                        state_reg <= S_ZERO;
                    end
                end
                S_ZERO: begin
                    if (stat.fill == 6'd63) begin
                        state_reg <= S_WAIT;
                        extra_reg <= 1'b1;
                    end else if (stat.fill == 6'd55) begin
                        state_reg <= S_LEN;
                    end
                end
                S_LEN: begin
                    if (stat.fill == 6'd63) begin
                        last_reg  <= 1'b1;
                        state_reg <= S_WAIT;
                    end
                end
                S_OUT: begin
                    if (out_ready) begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7) state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = (state_reg == S_OUT);
    assign out_index = idx_reg;

`ifndef SYNTHESIS
    a_out_order: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_ready && idx_reg != 3'd7 |=> out_valid && idx_reg == $past(idx_reg) + 3'd1)
        else $error("digest words out of order");
    a_no_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> !in_ready)
        else $error("input taken during digest output");
    a_len_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_LEN |-> stat.fill >= 6'd56)
        else $error("length written below byte 56");
`endif

endmodule

// ===== hdl/sha256_message_digest.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message digest
// Hashes a byte stream; emits eight digest words at each end of message.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                       | tuser / tlast
//  s_      | in  | [7:0] data_byte             | tuser[0] byte_valid, tlast end_of_message
//  m_      | out | [31:0] digest_word, [34:32] word_index | tlast last_word
//
// A byte beat is taken while idle; the beat filling a block holds input
// until the round loop is done. End of message adds padding writes, one
// or two compressions and 8 output beats. Reset is synchronous; no
// clearing pass. m_tready low stalls output words.
// ----------------------------------------------------------------------------
module sha256_message_digest (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_valid
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_tlast
);

    sha256_pkg::dp_cmd_t  cmd;
    sha256_pkg::dp_stat_t stat;
    sha256_pkg::word_t    h0;
    logic [2:0]           idx;

    sha256_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .byte_valid     (s_tuser),
        .end_of_message (s_tlast),
        .stat           (stat),
        .cmd            (cmd),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_index      (idx)
    );

    sha256_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .data_byte (s_tdata),
        .stat      (stat),
        .h0        (h0)
    );

    assign m_tdata = {5'd0, idx, h0};
    assign m_tlast = (idx == 3'd7);

endmodule

// ===== verif/sha256_digest_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches the byte and digest channels and keeps its own running hash of every
// accepted byte beat. On each end of message it pads the block, queues the eight
// expected digest words and compares each digest beat against them in order.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_valid
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
    input  logic        m_tlast,
    output int          error_count,
    output int          words_pending
);

    typedef struct {
        sha256_pkg::word_t digest;
        logic [2:0]        index;
        logic              last;
    } digest_beat_t;

    sha256_pkg::word_t chain [8];
    logic [7:0]        blk [64];
    int unsigned       fill;
    logic [63:0]       bit_len;
    digest_beat_t      digest_q [$];

    function automatic sha256_pkg::word_t rotr(sha256_pkg::word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        sha256_pkg::word_t w [16];
        sha256_pkg::word_t v [8];
        sha256_pkg::word_t wv, t1, t2, x15, x2;
        for (int j = 0; j < 16; j++)
            w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
        for (int j = 0; j < 8; j++) v[j] = chain[j];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                wv = w[r];
            end else begin
                x15 = w[(r-15) & 15];
                x2  = w[(r-2) & 15];
                wv = w[r & 15] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
                   + w[(r-7) & 15] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
                w[r & 15] = wv;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundK[r] + wv;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) chain[j] += v[j];
    endtask

    task automatic restart_message();
        for (int j = 0; j < 8; j++) chain[j] = sha256_pkg::InitH[j];
        fill = 0;
        bit_len = '0;
    endtask

    task automatic absorb_beat(logic [7:0] data, logic has_byte, logic eom);
        int unsigned pos;
        digest_beat_t b;
        if (has_byte) begin
            blk[fill] = data;
            fill++;
            bit_len += 64'd8;
            if (fill == 64) begin
                compress_block();
                fill = 0;
            end
        end
        if (eom) begin
            pos = fill;
            blk[pos] = sha256_pkg::PadByte;
            pos++;
            if (pos > 56) begin
                while (pos < 64) begin
                    blk[pos] = 8'h00;
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < 56) begin
                blk[pos] = 8'h00;
                pos++;
            end
            for (int j = 0; j < 8; j++) blk[56+j] = bit_len[63-8*j -: 8];
            compress_block();
            for (int j = 0; j < 8; j++) begin
                b.digest = chain[j];
                b.index  = 3'(j);
                b.last   = (j == 7);
                digest_q = {digest_q, b};
            end
            restart_message();
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        digest_beat_t e;
        if (!aresetn) begin
            restart_message();
            digest_q.delete();
            error_count   = 0;
            words_pending = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (digest_q.size() == 0) begin
                    report_mismatch("unexpected digest beat", m_tdata, 0);
                end else begin
                    e = digest_q.pop_front();
                    if (m_tdata[31:0] !== e.digest)
                        report_mismatch("digest_word", m_tdata[31:0], e.digest);
                    if (m_tdata[34:32] !== e.index)
                        report_mismatch("word_index", m_tdata[34:32], e.index);
                    if (m_tlast !== e.last)
                        report_mismatch("last_word", m_tlast, e.last);
                end
            end
            if (s_tvalid && s_tready)
                absorb_beat(s_tdata, s_tuser, s_tlast);
            words_pending = digest_q.size();
        end
    end

endmodule

// ===== verif/sha256_message_digest_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message digest testbench
// Drives byte beats with random gaps and output stalls: empty and short
// messages, padding edge lengths, multi-block messages and idle beats.
// The checker predicts each digest; this top reports the verdict.
// ----------------------------------------------------------------------------
module sha256_message_digest_tb;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    int          error_count;
    int          words_pending;
    int          out_wait;

    sha256_message_digest uut (.*);

    sha256_digest_checker checker_i (.*);

    always begin
        aclk = 1'b1; #6;
        aclk = 1'b0; #6;
    end

    // sends one beat, with a random gap before it
    task automatic send_beat(logic [7:0] data, logic has_byte, logic eom);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has_byte;
        s_tlast  <= eom;
        do @(posedge aclk); while (!s_tready);
    endtask

    // message of len bytes, last byte carries end of message (len 0: bare end)
    task automatic send_message(int len, bit noise);
        for (int i = 0; i < len; i++) begin
            if (noise && $urandom_range(0, 7) == 0)
                send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(8'($urandom), 1'b1, i == len - 1);
        end
        if (len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
    endtask

    // output side: after each digest beat, hold off ready for a random wait, possibly none
    always @(posedge aclk) begin
        int nxt;
        if (!aresetn) begin
            m_tready <= 1'b0;
            out_wait <= $urandom_range(0, 4);
        end else if (m_tvalid && m_tready) begin
            nxt = $urandom_range(0, 4);
            out_wait <= nxt;
            m_tready <= (nxt == 0);
        end else if (out_wait != 0) begin
            out_wait <= out_wait - 1;
            m_tready <= (out_wait == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        int len;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        s_tlast  <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty message, extreme bytes, padding boundaries
        send_message(0, 0);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'hff, 1'b1, 1'b1);
        send_beat(8'h5a, 1'b0, 1'b0);
        send_beat(8'ha5, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        drain_results();
        send_message(3, 0);
        send_message(55, 0);
        send_message(56, 0);
        drain_results();
        send_message(63, 0);
        send_message(64, 0);
        send_message(65, 1);

        // random: mostly short messages, a few of 56 to 72 bytes
        len = 0;
        while (len < 100) begin
            int n;
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(56, 72)
                                             : $urandom_range(0, 12);
            send_message(n, 1);
            len += n + 1;
            if ($urandom_range(0, 9) == 0) drain_results();
        end
        drain_results();
        repeat (200) @(posedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
